>>> sv/oaht_pkg.sv
// shared types and constants for the open addressing hash table
`default_nettype none
package oaht_pkg;

  localparam int MAX_CAPACITY_BITS = 10;
  localparam int MAX_PROBES        = 32;

  localparam int KEY_W   = 64;
  localparam int VAL_W   = 64;
  localparam int CAP_W   = 4;
  localparam int SLOT_W  = MAX_CAPACITY_BITS;
  localparam int COUNT_W = SLOT_W + 1;
  localparam int EFF_W   = $clog2(MAX_CAPACITY_BITS + 1);
  localparam int PROBE_W = $clog2(MAX_PROBES + 1);
  localparam int CFG_IDX_W = 1;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_FIND   = 2'd1,
    REQ_REMOVE = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_FOUND   = 2'd1,
    ST_FULL        = 2'd2,
    ST_PROBE_LIMIT = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY_BITS = 1'b0,
    CFG_TOMB_VALUE    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic [VAL_W-1:0]   value_out;
    logic [SLOT_W-1:0]  slot_index;
    logic [COUNT_W-1:0] live_entries;
  } rsp_t;

  typedef struct packed {
    logic [SLOT_W-1:0] raddr;
    logic [SLOT_W-1:0] waddr;
    logic              key_we;
    logic [KEY_W-1:0]  key_wdata;
    logic              val_we;
    logic [VAL_W-1:0]  val_wdata;
  } mem_ctl_t;

endpackage
`default_nettype wire

>>> sv/oaht_ram.sv
// simple dual port ram with registered read data
`default_nettype none
module oaht_ram #(
  parameter int WIDTH  = 64,
  parameter int ADDR_W = 10
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [2**ADDR_W];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> sv/oaht_ctrl.sv
// probe sequencer: clearing pass, quadratic probe walk and table update
`default_nettype none
module oaht_ctrl import oaht_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire req_t               in_req_i,
  input  wire logic [CAP_W-1:0]   cap_i,
  input  wire logic [VAL_W-1:0]   tomb_i,
  input  wire logic               out_free_i,
  output logic                    res_valid_o,
  output rsp_t                    res_o,
  output mem_ctl_t                mem_o,
  input  wire logic [KEY_W-1:0]   key_rdata_i,
  input  wire logic [VAL_W-1:0]   val_rdata_i
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_PROBE = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [SLOT_W-1:0]  clr_q, clr_d;
  req_t               req_q, req_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [SLOT_W-1:0]  sq_q, sq_d;
  logic [PROBE_W-1:0] n_q, n_d;
  logic [COUNT_W-1:0] used_q, used_d;
  logic [COUNT_W-1:0] live_q, live_d;
  rsp_t               rsp_q, rsp_d;

  logic [EFF_W-1:0]   eff_bits;
  logic [SLOT_W-1:0]  mask;
  logic [COUNT_W-1:0] half_cap;
  logic [SLOT_W-1:0]  home_slot;
  logic [SLOT_W-1:0]  next_slot;
  logic               empty, hit, tomb;
  logic               is_add, is_lookup;

  always_comb begin
    if (cap_i == '0) begin
      eff_bits = EFF_W'(1);
    end else if (int'(cap_i) > MAX_CAPACITY_BITS) begin
      eff_bits = EFF_W'(MAX_CAPACITY_BITS);
    end else begin
      eff_bits = EFF_W'(cap_i);
    end
  end

  assign mask      = ~({SLOT_W{1'b1}} << eff_bits);
  assign half_cap  = {{(COUNT_W-1){1'b0}}, 1'b1} << (eff_bits - EFF_W'(1));
  assign home_slot = in_req_i.key[SLOT_W-1:0] & mask;
  assign next_slot = (slot_q + sq_q) & mask;

  assign empty = (key_rdata_i == '0);
  assign hit   = (key_rdata_i == req_q.key);
  assign tomb  = (val_rdata_i == tomb_i);

  assign is_add    = (in_req_i.req_type == REQ_ADD);
  assign is_lookup = (in_req_i.req_type == REQ_FIND) || (in_req_i.req_type == REQ_REMOVE);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    req_d       = req_q;
    slot_d      = slot_q;
    sq_d        = sq_q;
    n_d         = n_q;
    used_d      = used_q;
    live_d      = live_q;
    rsp_d       = rsp_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_o.raddr     = slot_q;
    mem_o.waddr     = slot_q;
    mem_o.key_we    = 1'b0;
    mem_o.key_wdata = req_q.key;
    mem_o.val_we    = 1'b0;
    mem_o.val_wdata = req_q.value;

    unique case (state_q)
      S_CLEAR: begin
        mem_o.waddr     = clr_q;
        mem_o.key_we    = 1'b1;
        mem_o.key_wdata = '0;
        clr_d           = clr_q + SLOT_W'(1);
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o  = 1'b1;
        mem_o.raddr = home_slot;
        if (in_valid_i) begin
          req_d  = in_req_i;
          slot_d = home_slot;
          n_d    = PROBE_W'(1);
          sq_d   = SLOT_W'(1);
          rsp_d  = '0;
          rsp_d.status = ST_NOT_FOUND;
          if (in_req_i.key == '0 || !(is_add || is_lookup)) begin
            state_d = S_DONE;
          end else if (is_add && used_q >= half_cap) begin
            rsp_d.status = ST_FULL;
            state_d      = S_DONE;
          end else begin
            state_d = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        mem_o.raddr = next_slot;
        if (req_q.req_type == REQ_ADD && (empty || (hit && tomb))) begin
          mem_o.key_we      = 1'b1;
          mem_o.val_we      = 1'b1;
          used_d            = used_q + COUNT_W'(1);
          live_d            = live_q + COUNT_W'(1);
          rsp_d.status      = ST_OK;
          rsp_d.slot_index  = slot_q;
          state_d           = S_DONE;
        end else if (req_q.req_type != REQ_ADD && (empty || (hit && tomb))) begin
          rsp_d.status = ST_NOT_FOUND;
          state_d      = S_DONE;
        end else if (req_q.req_type != REQ_ADD && hit) begin
          rsp_d.status     = ST_OK;
          rsp_d.found      = 1'b1;
          rsp_d.value_out  = val_rdata_i;
          rsp_d.slot_index = slot_q;
          if (req_q.req_type == REQ_REMOVE) begin
            mem_o.val_we    = 1'b1;
            mem_o.val_wdata = tomb_i;
            if (live_q != '0) begin
              live_d = live_q - COUNT_W'(1);
            end
          end
          state_d = S_DONE;
        end else if (n_q == PROBE_W'(MAX_PROBES)) begin
          rsp_d.status = ST_PROBE_LIMIT;
          state_d      = S_DONE;
        end else begin
          slot_d = next_slot;
          n_d    = n_q + PROBE_W'(1);
          sq_d   = sq_q + SLOT_W'({n_q, 1'b1});
        end
      end
      S_DONE: begin
        res_valid_o = out_free_i;
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    res_o              = rsp_q;
    res_o.live_entries = live_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      used_q  <= '0;
      live_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      used_q  <= used_d;
      live_q  <= live_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    slot_q <= slot_d;
    sq_q   <= sq_d;
    n_q    <= n_d;
    rsp_q  <= rsp_d;
  end

endmodule
`default_nettype wire

>>> sv/open_addressing_hash_table_core.sv
// top level of the open addressing hash table with quadratic probing
//
// requests (add, find, remove) enter on the in channel, one at a time; each
// gives exactly one response on the out channel. the home slot is the key's
// low capacity bits and each probe step adds n squared, n counting from 1.
// each probe reads one slot of the key and value memories; a request walks up
// to MAX_PROBES slots. requests with key zero, an unknown type or a full
// table finish without probing. the probe walk is what sets the rate.
// the response sits in an output register; a new request is taken while it
// waits, and a stalled receiver only holds the block once a second response
// is ready. after reset the block runs a clearing pass over all
// 2**MAX_CAPACITY_BITS key slots and takes no request meanwhile.
// configuration writes (capacity_bits, tomb_value) are always accepted and
// reset to 10 and all ones.
`default_nettype none
module open_addressing_hash_table_core import oaht_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire req_t                 in_req_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output rsp_t                      out_rsp_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [63:0]          cfg_data_i
);

  logic [CAP_W-1:0] cap_q;
  logic [VAL_W-1:0] tomb_q;
  logic             out_valid_q;
  rsp_t             out_rsp_q;
  logic             out_free;
  logic             res_valid;
  rsp_t             res;
  mem_ctl_t         mem;
  logic [KEY_W-1:0] key_rdata;
  logic [VAL_W-1:0] val_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CAP_W'(MAX_CAPACITY_BITS);
      tomb_q <= '1;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_i)
        CFG_CAPACITY_BITS: cap_q  <= cfg_data_i[CAP_W-1:0];
        CFG_TOMB_VALUE:    tomb_q <= cfg_data_i[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // one deep output register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_rsp_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  oaht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .cap_i       (cap_q),
    .tomb_i      (tomb_q),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_o       (mem),
    .key_rdata_i (key_rdata),
    .val_rdata_i (val_rdata)
  );

  oaht_ram #(
    .WIDTH  (KEY_W),
    .ADDR_W (SLOT_W)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (mem.key_we),
    .waddr_i (mem.waddr),
    .wdata_i (mem.key_wdata),
    .raddr_i (mem.raddr),
    .rdata_o (key_rdata)
  );

  oaht_ram #(
    .WIDTH  (VAL_W),
    .ADDR_W (SLOT_W)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (mem.val_we),
    .waddr_i (mem.waddr),
    .wdata_i (mem.val_wdata),
    .raddr_i (mem.raddr),
    .rdata_o (val_rdata)
  );

endmodule
`default_nettype wire

>>> dv/open_addressing_hash_table_core_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the open addressing hash table core: directed and random requests
module open_addressing_hash_table_core_test import oaht_pkg::*;;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int         SLOTS       = 1 << MAX_CAPACITY_BITS;
  localparam int         IDLE_LIMIT  = 4096;
  localparam int         KEEP_KEYS   = 48;

  typedef struct {
    bit          is_cfg;
    cfg_idx_e    idx;
    logic [63:0] data;
    req_t        req;
    bit          typed;
    rsp_t        rsp;
  } step_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  req_t                 in_req_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  rsp_t                 out_rsp_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [63:0]          cfg_data_i;

  open_addressing_hash_table_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  logic [KEY_W-1:0] slot_keys [SLOTS];
  logic [VAL_W-1:0] slot_vals [SLOTS];
  int unsigned      adds_taken;
  int unsigned      live_now;
  logic [CAP_W-1:0] cap_bits;
  logic [63:0]      tomb;

  rsp_t             responses_due [$];
  logic [KEY_W-1:0] known_keys [$];
  int               errors;
  int               idle_cycles;
  int               rsp_count;
  bit               calm;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic rsp_t apply_request(req_t r);
    rsp_t        rsp;
    int unsigned bits;
    int unsigned mask;
    int unsigned slot;
    bit          done;
    rsp = '0;
    rsp.status = ST_NOT_FOUND;
    done = 1'b0;
    bits = (cap_bits < 1) ? 1 : (cap_bits > MAX_CAPACITY_BITS) ? MAX_CAPACITY_BITS : cap_bits;
    mask = (1 << bits) - 1;
    slot = r.key[31:0] & mask;
    if (r.key != '0 && r.req_type == REQ_ADD) begin
      if (adds_taken >= ((1 << bits) >> 1)) begin
        rsp.status = ST_FULL;
      end else begin
        rsp.status = ST_PROBE_LIMIT;
        for (int n = 1; n <= MAX_PROBES && !done; n++) begin
          if (slot_keys[slot] == '0 || (slot_keys[slot] == r.key && slot_vals[slot] == tomb)) begin
            slot_keys[slot] = r.key;
            slot_vals[slot] = r.value;
            adds_taken++;
            live_now++;
            rsp.status = ST_OK;
            rsp.slot_index = SLOT_W'(slot);
            done = 1'b1;
          end else begin
            slot = (slot + n * n) & mask;
          end
        end
      end
    end else if (r.key != '0 && (r.req_type == REQ_FIND || r.req_type == REQ_REMOVE)) begin
      rsp.status = ST_PROBE_LIMIT;
      for (int n = 1; n <= MAX_PROBES && !done; n++) begin
        if (slot_keys[slot] == '0) begin
          rsp.status = ST_NOT_FOUND;
          done = 1'b1;
        end else if (slot_keys[slot] == r.key) begin
          done = 1'b1;
          if (slot_vals[slot] == tomb) begin
            rsp.status = ST_NOT_FOUND;
          end else begin
            rsp.status = ST_OK;
            rsp.found = 1'b1;
            rsp.value_out = slot_vals[slot];
            rsp.slot_index = SLOT_W'(slot);
            if (r.req_type == REQ_REMOVE) begin
              slot_vals[slot] = tomb;
              if (live_now > 0) live_now--;
            end
          end
        end else begin
          slot = (slot + n * n) & mask;
        end
      end
    end
    rsp.live_entries = COUNT_W'(live_now);
    return rsp;
  endfunction

  function automatic step_t req_row(logic [1:0] t, logic [63:0] k, logic [63:0] v);
    step_t s;
    s = '{idx: CFG_CAPACITY_BITS, default: '0};
    s.req.req_type = t;
    s.req.key = k;
    s.req.value = v;
    return s;
  endfunction

  function automatic step_t typed_row(logic [1:0] t, logic [63:0] k, logic [63:0] v,
                                      status_e st, logic f, logic [63:0] vo, int slot, int live);
    step_t s;
    s = req_row(t, k, v);
    s.typed = 1'b1;
    s.rsp.status = st;
    s.rsp.found = f;
    s.rsp.value_out = vo;
    s.rsp.slot_index = SLOT_W'(slot);
    s.rsp.live_entries = COUNT_W'(live);
    return s;
  endfunction

  function automatic step_t cfg_row(cfg_idx_e i, logic [63:0] d);
    step_t s;
    s = '{idx: i, default: '0};
    s.is_cfg = 1'b1;
    s.data = d;
    return s;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(bit from_known);
    logic [KEY_W-1:0] k;
    if (from_known && known_keys.size() > 0)
      return known_keys[$urandom_range(0, known_keys.size() - 1)];
    k = {$urandom, $urandom};
    if ($urandom_range(0, 2) == 0) k[SLOT_W-1:0] = SLOT_W'($urandom_range(0, 15));
    if (k == '0) k = 64'd1;
    return k;
  endfunction

  task automatic send_req(input req_t r, input bit typed, input rsp_t want);
    int   gap;
    rsp_t predicted;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = apply_request(r);
    responses_due.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (responses_due.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] data);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_CAPACITY_BITS) cap_bits = data[CAP_W-1:0];
    else tomb = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_req(output req_t r, output bit noise);
    int roll;
    roll = $urandom_range(0, 99);
    noise = 1'b0;
    r.value = {$urandom, $urandom};
    if (roll < 40) begin
      r.req_type = REQ_ADD;
      r.key = pick_key($urandom_range(0, 1));
      if ($urandom_range(0, 7) == 0) r.value = tomb;
      known_keys.push_back(r.key);
      if (known_keys.size() > KEEP_KEYS) void'(known_keys.pop_front());
    end else if (roll < 70) begin
      r.req_type = REQ_FIND;
      r.key = pick_key($urandom_range(0, 4) != 0);
    end else if (roll < 92) begin
      r.req_type = REQ_REMOVE;
      r.key = pick_key($urandom_range(0, 4) != 0);
    end else begin
      noise = 1'b1;
      if (roll < 96) begin
        r.req_type = 2'($urandom_range(0, 3));
        r.key = '0;
      end else begin
        r.req_type = REQ_UNKNOWN;
        r.key = pick_key($urandom_range(0, 1));
      end
    end
  endtask

  // fill every slot on one probe path, then add and find a key homed at its start
  task automatic probe_chain();
    int unsigned home;
    int unsigned offset;
    req_t        r;
    home = $urandom_range(0, SLOTS - 1);
    offset = 0;
    r.req_type = REQ_ADD;
    for (int i = 0; i < MAX_PROBES; i++) begin
      r.key = {$urandom | 32'h1, $urandom};
      r.key[SLOT_W-1:0] = SLOT_W'(home + offset);
      r.value = {$urandom, $urandom};
      offset += (i + 1) * (i + 1);
      send_req(r, 1'b0, '0);
    end
    r.key = {$urandom | 32'h1, $urandom};
    r.key[SLOT_W-1:0] = SLOT_W'(home);
    send_req(r, 1'b0, '0);
    r.req_type = REQ_FIND;
    send_req(r, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      rsp_count++;
      if (responses_due.size() == 0) begin
        errors++;
        $display("%0t: response with no request pending, expected none, actual %h",
                 $time, out_rsp_o);
      end else begin
        want = responses_due.pop_front();
        check_field("status", 64'(want.status), 64'(out_rsp_o.status));
        check_field("found", 64'(want.found), 64'(out_rsp_o.found));
        check_field("value_out", want.value_out, out_rsp_o.value_out);
        check_field("slot_index", 64'(want.slot_index), 64'(out_rsp_o.slot_index));
        check_field("live_entries", 64'(want.live_entries), 64'(out_rsp_o.live_entries));
      end
    end
  end

  initial begin
    int hold;
    int seen;
    out_ready_i = 1'b0;
    hold = 0;
    seen = 0;
    forever begin
      @(negedge clk_i);
      if (rsp_count != seen) begin
        seen = rsp_count;
        hold = calm ? 0 : $urandom_range(0, 3);
      end
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    step_t            dir_tbl [$];
    req_t             r;
    bit               noise;
    bit               chain;
    logic [CAP_W-1:0] cap_w;
    logic [63:0]      tomb_w;
    logic [63:0]      cfg_word;
    int               n_items;
    int               count;
    errors      = 0;
    idle_cycles = 0;
    rsp_count   = 0;
    calm        = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    cfg_valid_i = 1'b0;
    cfg_idx_i   = CFG_CAPACITY_BITS;
    cfg_data_i  = '0;
    adds_taken  = 0;
    live_now    = 0;
    cap_bits    = CAP_W'(MAX_CAPACITY_BITS);
    tomb        = '1;
    for (int i = 0; i < SLOTS; i++) begin
      slot_keys[i] = '0;
      slot_vals[i] = '0;
    end

    dir_tbl.push_back(typed_row(REQ_FIND,    64'd1,   '0,    ST_NOT_FOUND,   1'b0, '0, 0, 0));
    dir_tbl.push_back(typed_row(REQ_REMOVE,  '1,      '0,    ST_NOT_FOUND,   1'b0, '0, 0, 0));
    dir_tbl.push_back(typed_row(REQ_ADD,     '0,      64'd5, ST_NOT_FOUND,   1'b0, '0, 0, 0));
    dir_tbl.push_back(typed_row(REQ_UNKNOWN, 64'd5,   '0,    ST_NOT_FOUND,   1'b0, '0, 0, 0));
    dir_tbl.push_back(typed_row(REQ_ADD,     64'h400, '0,    ST_OK,          1'b0, '0, 0, 1));
    dir_tbl.push_back(typed_row(REQ_ADD,     64'h401, '1,    ST_OK,          1'b0, '0, 1, 2));
    dir_tbl.push_back(typed_row(REQ_FIND,    64'h401, '0,    ST_NOT_FOUND,   1'b0, '0, 0, 2));
    dir_tbl.push_back(typed_row(REQ_FIND,    64'h400, '0,    ST_OK,          1'b1, '0, 0, 2));
    dir_tbl.push_back(req_row(REQ_ADD,       64'h400, 64'h5555_5555_5555_5555));
    dir_tbl.push_back(req_row(REQ_ADD,       '1,      64'haaaa_aaaa_aaaa_aaaa));
    dir_tbl.push_back(req_row(REQ_FIND,      '1,      '0));
    dir_tbl.push_back(req_row(REQ_REMOVE,    '1,      '0));
    dir_tbl.push_back(req_row(REQ_FIND,      '1,      '0));
    dir_tbl.push_back(req_row(REQ_REMOVE,    '1,      '0));
    dir_tbl.push_back(req_row(REQ_ADD,       '1,      64'd1));
    dir_tbl.push_back(req_row(REQ_ADD,       64'd1,   '1));
    dir_tbl.push_back(typed_row(REQ_REMOVE,  64'h400, '0,    ST_OK,          1'b1, '0, 0, 4));
    dir_tbl.push_back(cfg_row(CFG_CAPACITY_BITS, 64'd0));
    dir_tbl.push_back(typed_row(REQ_FIND,    64'd2,   '0,    ST_PROBE_LIMIT, 1'b0, '0, 0, 4));
    dir_tbl.push_back(typed_row(REQ_ADD,     64'd2,   64'd7, ST_FULL,        1'b0, '0, 0, 4));
    dir_tbl.push_back(req_row(REQ_REMOVE,    64'h401, '0));
    dir_tbl.push_back(cfg_row(CFG_TOMB_VALUE, '0));
    dir_tbl.push_back(cfg_row(CFG_CAPACITY_BITS, 64'd15));
    dir_tbl.push_back(req_row(REQ_FIND,      64'h401, '0));
    dir_tbl.push_back(req_row(REQ_FIND,      64'h400, '0));
    dir_tbl.push_back(req_row(REQ_UNKNOWN,   '1,      '1));

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].is_cfg) write_reg(dir_tbl[i].idx, dir_tbl[i].data);
      else send_req(dir_tbl[i].req, dir_tbl[i].typed, dir_tbl[i].rsp);
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          cap_w = 4'd5;  tomb_w = '1;                  n_items = 80;  chain = 1'b0;
        end
        1: begin
          cap_w = 4'd1;  tomb_w = {$urandom, $urandom}; n_items = 60;  chain = 1'b0;
        end
        2: begin
          cap_w = 4'd10; tomb_w = {$urandom, $urandom}; n_items = 430; chain = 1'b1;
        end
        3: begin
          cap_w = 4'd4;  tomb_w = '0;                  n_items = 60;  chain = 1'b0;
        end
        4: begin
          cap_w = 4'd12; tomb_w = '1;                  n_items = 360; chain = 1'b1;
        end
        default: begin
          cap_w = 4'd10; tomb_w = {$urandom, $urandom}; n_items = 260; chain = 1'b0;
        end
      endcase
      cfg_word = {$urandom, $urandom};
      cfg_word[CAP_W-1:0] = cap_w;
      write_reg(CFG_CAPACITY_BITS, cfg_word);
      write_reg(CFG_TOMB_VALUE, tomb_w);
      if (chain) probe_chain();
      count = 0;
      while (count < n_items) begin
        if (count % 100 == 0) calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 199) == 0) wait_drained();
        random_req(r, noise);
        send_req(r, 1'b0, '0);
        if (!noise) count++;
      end
    end

    wait_drained();
    repeat (2 * MAX_PROBES) @(negedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/oaht_pkg.sv
sv/oaht_ram.sv
sv/oaht_ctrl.sv
sv/open_addressing_hash_table_core.sv
dv/open_addressing_hash_table_core_test.sv
